// File: design/tcf_pkg.sv
// Package for the tilt complementary filter: shared constants, the arctangent
// table, register index codes, control structs and the angle saturation function.
// Depends on nothing; every design file refers to it by scoped names.
package tcf_pkg;

    localparam int IN_W    = 144;
    localparam int OUT_W   = 96;
    localparam int CORD_W  = 36;
    localparam int INCR_W  = 36;
    localparam int PROD_W  = 44;

    localparam logic signed [31:0] ANG_LIMIT = 32'sd2000000000;
    localparam logic signed [31:0] DEG90     = 32'sd90000000;
    localparam logic signed [31:0] DEG180    = 32'sd180000000;

    // Register index codes on the configuration port.
    localparam logic [2:0] REG_BLEND_WEIGHT = 3'd0;
    localparam logic [2:0] REG_YAW_ENABLE   = 3'd1;
    localparam logic [2:0] REG_DRIFT_LIMIT  = 3'd2;
    localparam logic [2:0] REG_ACCEL_LOW    = 3'd3;
    localparam logic [2:0] REG_ACCEL_HIGH   = 3'd4;
    localparam logic [2:0] REG_GYRO_MIN     = 3'd5;

    // Fusion mode codes.
    localparam logic [1:0] MODE_BLEND = 2'd0;
    localparam logic [1:0] MODE_GYRO  = 2'd1;
    localparam logic [1:0] MODE_ACCEL = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    // atan(2^-i) in microdegrees, rounded to nearest.
    localparam logic signed [31:0] ATAN_TAB [32] = '{
        32'sd45000000, 32'sd26565051, 32'sd14036243, 32'sd7125016,
        32'sd3576334,  32'sd1789911,  32'sd895174,   32'sd447614,
        32'sd223811,   32'sd111906,   32'sd55953,    32'sd27976,
        32'sd13988,    32'sd6994,     32'sd3497,     32'sd1749,
        32'sd874,      32'sd437,      32'sd219,      32'sd109,
        32'sd55,       32'sd27,       32'sd14,       32'sd7,
        32'sd3,        32'sd2,        32'sd1,        32'sd0,
        32'sd0,        32'sd0,        32'sd0,        32'sd0
    };

    // Per-item control that the sequencer hands to both fusion lanes.
    typedef struct packed {
        logic       load_gyro;
        logic       load_prod;
        logic       seed;
        logic [1:0] mode;
    } fuse_ctl_t;

    // Clamp a wide angle to the legal microdegree range.
    function automatic logic signed [31:0] sat_angle(input logic signed [39:0] v);
        logic signed [39:0] lim;
        lim = 40'(ANG_LIMIT);
        if (v > lim) begin
            return ANG_LIMIT;
        end else if (v < -lim) begin
            return -ANG_LIMIT;
        end
        return v[31:0];
    endfunction

endpackage

// File: design/tcf_cordic.sv
// Iterative vectoring CORDIC lane: one rotation per cycle, returns atan2(y, x)
// minus 90 degrees in microdegrees. Depends on tcf_pkg.
module tcf_cordic #(
    parameter int STEPS = 18
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [15:0]       y_in,
    input  logic signed [15:0]       x_in,
    output logic                     busy,
    output logic signed [31:0]       angle
);
    localparam int CNT_W = $clog2(STEPS + 1);

    logic                             busy_reg;
    logic [CNT_W-1:0]                 step_reg;
    logic                             zero_reg;
    logic signed [tcf_pkg::CORD_W-1:0] x_reg, y_reg;
    logic signed [31:0]               z_reg;
    logic signed [tcf_pkg::CORD_W-1:0] x_ld, y_ld;
    logic [4:0]                       tab_idx;

    // Inputs scaled by 2^16 into the working width.
    assign x_ld    = {{4{x_in[15]}}, x_in, 16'b0};
    assign y_ld    = {{4{y_in[15]}}, y_in, 16'b0};
    assign tab_idx = 5'(step_reg);

    // Control: count the rotations.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            if (step_reg == CNT_W'(STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
            step_reg <= step_reg + 1'b1;
        end
    end

    // Datapath: pre-rotation for negative x, then one micro-rotation a cycle.
    always_ff @(posedge aclk) begin
        if (start) begin
            zero_reg <= (x_in == 16'sd0) && (y_in == 16'sd0);
            if (x_in < 16'sd0) begin
                x_reg <= -x_ld;
                y_reg <= -y_ld;
                z_reg <= (y_in >= 16'sd0) ? tcf_pkg::DEG180 : -tcf_pkg::DEG180;
            end else begin
                x_reg <= x_ld;
                y_reg <= y_ld;
                z_reg <= '0;
            end
        end else if (busy_reg) begin
            if (!y_reg[tcf_pkg::CORD_W-1]) begin
                x_reg <= x_reg + (y_reg >>> step_reg);
                y_reg <= y_reg - (x_reg >>> step_reg);
                z_reg <= z_reg + tcf_pkg::ATAN_TAB[tab_idx];
            end else begin
                x_reg <= x_reg - (y_reg >>> step_reg);
                y_reg <= y_reg + (x_reg >>> step_reg);
                z_reg <= z_reg - tcf_pkg::ATAN_TAB[tab_idx];
            end
        end
    end

    assign busy  = busy_reg;
    assign angle = (zero_reg ? 32'sd0 : z_reg) - tcf_pkg::DEG90;

endmodule

// File: design/tcf_incr.sv
// Angle increment lane: rate * elapsed_us / 1000, rounded half away from zero.
// One multiply, then a reciprocal multiplication by 1/1000 built from four
// partial products, one per cycle. Depends on tcf_pkg.
module tcf_incr (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  logic signed [22:0]                rate,
    input  logic [19:0]                       elapsed_us,
    output logic                              busy,
    output logic signed [tcf_pkg::INCR_W-1:0] incr
);
    // n / 1000 = floor((n >> 3) / 125); the shifted value is below 2^40, and
    // ceil(2^47 / 125) gives the exact quotient over that whole range.
    localparam logic [40:0] RECIP = 41'd1125899906843;
    localparam int          NUM_W = 40;
    localparam int          ACC_W = 81;
    localparam int          SHIFT = 47;
    localparam int          PARTS = 4;

    logic                              busy_reg, load_reg;
    logic [1:0]                        cnt_reg;
    logic signed [tcf_pkg::PROD_W-1:0] prod_reg;
    logic [NUM_W-1:0]                  num_reg;
    logic [ACC_W-1:0]                  acc_reg;
    logic                              neg_reg;
    logic signed [20:0]                dt_s;
    logic [tcf_pkg::PROD_W-1:0]        mag, biased;
    logic [19:0]                       n_part;
    logic [20:0]                       m_part;
    logic [40:0]                       part;
    logic [ACC_W-1:0]                  part_sh;
    logic [33:0]                       quot;

    assign dt_s   = signed'({1'b0, elapsed_us});
    assign mag    = prod_reg[tcf_pkg::PROD_W-1] ? unsigned'(-prod_reg) : unsigned'(prod_reg);
    assign biased = mag + tcf_pkg::PROD_W'(500);

    // One 20 x 21 partial product a cycle: the low bit of the count picks the
    // half of the numerator, the high bit the half of the reciprocal.
    always_comb begin
        n_part = cnt_reg[0] ? num_reg[39:20] : num_reg[19:0];
        m_part = cnt_reg[1] ? {1'b0, RECIP[40:21]} : RECIP[20:0];
        part   = n_part * m_part;
        case (cnt_reg)
            2'd0:    part_sh = ACC_W'(part);
            2'd1:    part_sh = ACC_W'(part) << 20;
            2'd2:    part_sh = ACC_W'(part) << 21;
            default: part_sh = ACC_W'(part) << 41;
        endcase
    end

    // Control: multiply cycle, load cycle, then the partial product steps.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            load_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            load_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (load_reg) begin
            load_reg <= 1'b0;
        end else if (busy_reg) begin
            if (cnt_reg == 2'(PARTS - 1)) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Datapath.
    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= rate * dt_s;
        end else if (load_reg) begin
            num_reg <= biased[NUM_W+2:3];
            neg_reg <= prod_reg[tcf_pkg::PROD_W-1];
            acc_reg <= '0;
        end else if (busy_reg) begin
            acc_reg <= acc_reg + part_sh;
        end
    end

    assign quot = acc_reg[ACC_W-1:SHIFT];
    assign busy = busy_reg;
    assign incr = neg_reg ? -signed'(tcf_pkg::INCR_W'(quot))
                          : signed'(tcf_pkg::INCR_W'(quot));

endmodule

// File: design/tcf_fuse.sv
// Fusion lane for one tilt axis: gyro angle with drift snap, blend multiply and
// rounding, then saturation. Depends on tcf_pkg.
module tcf_fuse (
    input  logic                              aclk,
    input  tcf_pkg::fuse_ctl_t                ctl,
    input  logic [15:0]                       blend_weight,
    input  logic [28:0]                       drift_limit,
    input  logic signed [31:0]                store,
    input  logic signed [31:0]                accel,
    input  logic signed [tcf_pkg::INCR_W-1:0] incr,
    output logic signed [31:0]                result
);
    logic signed [31:0] gyro_reg;
    logic signed [48:0] prod_g_reg;
    logic signed [48:0] prod_a_reg;
    logic signed [39:0] gyro_raw, diff;
    logic [39:0]        diff_mag;
    logic signed [49:0] sum;
    logic [49:0]        sum_mag;
    logic [33:0]        rnd;
    logic signed [39:0] res;
    logic signed [17:0] wg, wa;

    // Gyro angle, snapped to the accel angle when too far off.
    always_comb begin
        gyro_raw = ctl.seed ? 40'(accel) : 40'(store) + 40'(incr);
        diff     = gyro_raw - 40'(accel);
        diff_mag = diff[39] ? unsigned'(-diff) : unsigned'(diff);
    end

    always_ff @(posedge aclk) begin
        if (ctl.load_gyro) begin
            gyro_reg <= (diff_mag > 40'(drift_limit)) ? accel : gyro_raw[31:0];
        end
    end

    // Blend products.
    assign wg = signed'(18'(17'h10000 - 17'(blend_weight)));
    assign wa = signed'({2'b0, blend_weight});

    always_ff @(posedge aclk) begin
        if (ctl.load_prod) begin
            prod_g_reg <= wg * gyro_reg;
            prod_a_reg <= wa * accel;
        end
    end

    // Sum, round half away from zero, select by mode, saturate.
    always_comb begin
        sum     = 50'(prod_g_reg) + 50'(prod_a_reg);
        sum_mag = sum[49] ? unsigned'(-sum) : unsigned'(sum);
        rnd     = 34'((sum_mag + 50'd32768) >> 16);
        case (ctl.mode)
            tcf_pkg::MODE_BLEND: res = sum[49] ? -signed'(40'(rnd)) : signed'(40'(rnd));
            tcf_pkg::MODE_GYRO:  res = 40'(gyro_reg);
            default:             res = 40'(accel);
        endcase
        result = tcf_pkg::sat_angle(res);
    end

endmodule

// File: design/tilt_complementary_filter_unit.sv
// Tilt complementary filter: fuses gyro rates and accelerations into roll, pitch
// and yaw in microdegrees. Depends on tcf_pkg, tcf_cordic, tcf_incr, tcf_fuse.
//
// One sample at a time. An accepted transaction starts all lanes together: the
// two CORDIC lanes do one rotation a cycle, while the three rate-times-time lanes
// do a multiply, then a reciprocal multiplication by 1/1000 in four partial
// products; the merge states FUSE1, FUSE2 and FUSE3 then do the snap, the blend
// multiply and the rounding. s_tready returns in the cycle after the result is
// loaded, so a new sample is taken only once the last result has left the merge
// stage. A finished result waits in the output register and does not block the
// next sample; only a second result waits in the merge stage until the output
// register frees. The first sample after reset seeds roll and pitch from the
// accelerometer angles.
module tilt_complementary_filter_unit #(
    parameter int CORDIC_STEPS = 18
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // rate_roll[22:0], rate_pitch[45:23], rate_yaw[68:46], accel_x[84:69],
    // accel_y[100:85], accel_z[116:101], elapsed_us[136:117], zero fill above
    input  logic [tcf_pkg::IN_W-1:0]  s_tdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // roll_angle[31:0], pitch_angle[63:32], yaw_angle[95:64]
    output logic [tcf_pkg::OUT_W-1:0] m_tdata,
    // fusion_mode[1:0]
    output logic [1:0]                m_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic                      cfg_we,
    input  logic [2:0]                cfg_addr,
    input  logic [28:0]               cfg_wdata
);
    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RUN   = 5'b00010,
        ST_FUSE1 = 5'b00100,
        ST_FUSE2 = 5'b01000,
        ST_FUSE3 = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] blend_weight_reg;
    logic        yaw_enable_reg;
    logic [28:0] drift_limit_reg;
    logic [15:0] accel_low_reg, accel_high_reg;
    logic [22:0] gyro_min_reg;

    logic signed [31:0] roll_store_reg, pitch_store_reg, yaw_store_reg;
    logic               seed_reg;
    logic [1:0]         mode_reg;
    logic [tcf_pkg::OUT_W-1:0] m_tdata_reg;
    logic [1:0]         m_tuser_reg;
    logic               m_tvalid_reg;

    logic signed [22:0] rate_roll, rate_pitch, rate_yaw;
    logic signed [15:0] accel_x, accel_y, accel_z;
    logic [19:0]        elapsed_us;
    logic               accept, lanes_busy, out_free, out_load;
    logic [17:0]        asum;
    logic [24:0]        gsum;
    logic [1:0]         mode_next;
    logic [4:0]         busy_vec;
    logic signed [31:0] acc_roll, acc_pitch, roll_res, pitch_res, yaw_res;
    logic signed [tcf_pkg::INCR_W-1:0] incr_roll, incr_pitch, incr_yaw;
    tcf_pkg::fuse_ctl_t fuse_ctl;

    // Field unpacking.
    assign rate_roll  = s_tdata[22:0];
    assign rate_pitch = s_tdata[45:23];
    assign rate_yaw   = s_tdata[68:46];
    assign accel_x    = s_tdata[84:69];
    assign accel_y    = s_tdata[100:85];
    assign accel_z    = s_tdata[116:101];
    assign elapsed_us = s_tdata[136:117];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blend_weight_reg <= 16'd3277;
            yaw_enable_reg   <= 1'b0;
            drift_limit_reg  <= 29'd5000000;
            accel_low_reg    <= 16'd100;
            accel_high_reg   <= 16'd3000;
            gyro_min_reg     <= 23'd300;
        end else if (cfg_we) begin
            case (cfg_addr)
                tcf_pkg::REG_BLEND_WEIGHT: blend_weight_reg <= cfg_wdata[15:0];
                tcf_pkg::REG_YAW_ENABLE:   yaw_enable_reg   <= cfg_wdata[0];
                tcf_pkg::REG_DRIFT_LIMIT:  drift_limit_reg  <= cfg_wdata;
                tcf_pkg::REG_ACCEL_LOW:    accel_low_reg    <= cfg_wdata[15:0];
                tcf_pkg::REG_ACCEL_HIGH:   accel_high_reg   <= cfg_wdata[15:0];
                tcf_pkg::REG_GYRO_MIN:     gyro_min_reg     <= cfg_wdata[22:0];
                default: ;
            endcase
        end
    end

    // Mode decision from the absolute sums of the sample.
    always_comb begin
        asum = 18'(accel_x[15] ? -17'(accel_x) : 17'(accel_x))
             + 18'(accel_y[15] ? -17'(accel_y) : 17'(accel_y))
             + 18'(accel_z[15] ? -17'(accel_z) : 17'(accel_z));
        gsum = 25'(rate_roll[22] ? -24'(rate_roll) : 24'(rate_roll))
             + 25'(rate_pitch[22] ? -24'(rate_pitch) : 24'(rate_pitch))
             + 25'(rate_yaw[22] ? -24'(rate_yaw) : 24'(rate_yaw));
        if (asum > 18'(accel_low_reg) && asum < 18'(accel_high_reg)
            && gsum > 25'(gyro_min_reg)) begin
            mode_next = tcf_pkg::MODE_BLEND;
        end else if (gsum > 25'(gyro_min_reg)) begin
            mode_next = tcf_pkg::MODE_GYRO;
        end else begin
            mode_next = tcf_pkg::MODE_ACCEL;
        end
    end

    // Lanes: two CORDICs and three increment units.
    tcf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_roll (
        .aclk(aclk), .aresetn(aresetn), .start(accept),
        .y_in(accel_z), .x_in(accel_y), .busy(busy_vec[0]), .angle(acc_roll)
    );
    tcf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic_pitch (
        .aclk(aclk), .aresetn(aresetn), .start(accept),
        .y_in(accel_z), .x_in(accel_x), .busy(busy_vec[1]), .angle(acc_pitch)
    );
    tcf_incr u_incr_roll (
        .aclk(aclk), .aresetn(aresetn), .start(accept), .rate(rate_roll),
        .elapsed_us(elapsed_us), .busy(busy_vec[2]), .incr(incr_roll)
    );
    tcf_incr u_incr_pitch (
        .aclk(aclk), .aresetn(aresetn), .start(accept), .rate(rate_pitch),
        .elapsed_us(elapsed_us), .busy(busy_vec[3]), .incr(incr_pitch)
    );
    tcf_incr u_incr_yaw (
        .aclk(aclk), .aresetn(aresetn), .start(accept), .rate(rate_yaw),
        .elapsed_us(elapsed_us), .busy(busy_vec[4]), .incr(incr_yaw)
    );
    assign lanes_busy = |busy_vec;

    // Merge stage: one fusion lane per tilt axis.
    assign fuse_ctl.load_gyro = (state_reg == ST_FUSE1);
    assign fuse_ctl.load_prod = (state_reg == ST_FUSE2);
    assign fuse_ctl.seed      = seed_reg;
    assign fuse_ctl.mode      = mode_reg;

    tcf_fuse u_fuse_roll (
        .aclk(aclk), .ctl(fuse_ctl), .blend_weight(blend_weight_reg),
        .drift_limit(drift_limit_reg), .store(roll_store_reg), .accel(acc_roll),
        .incr(incr_roll), .result(roll_res)
    );
    tcf_fuse u_fuse_pitch (
        .aclk(aclk), .ctl(fuse_ctl), .blend_weight(blend_weight_reg),
        .drift_limit(drift_limit_reg), .store(pitch_store_reg), .accel(acc_pitch),
        .incr(incr_pitch), .result(pitch_res)
    );

    // Yaw integrates only once seeded and while enabled.
    assign yaw_res = (yaw_enable_reg && !seed_reg)
                   ? tcf_pkg::sat_angle(40'(yaw_store_reg) + 40'(incr_yaw)) : 32'sd0;

    assign out_free = !m_tvalid_reg || m_tready;
    assign out_load = (state_reg == ST_FUSE3) && out_free;

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_RUN;
            ST_RUN:   if (!lanes_busy) state_next = ST_FUSE1;
            ST_FUSE1: state_next = ST_FUSE2;
            ST_FUSE2: state_next = ST_FUSE3;
            ST_FUSE3: if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Control state, filter state and the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            seed_reg        <= 1'b1;
            roll_store_reg  <= '0;
            pitch_store_reg <= '0;
            yaw_store_reg   <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                seed_reg        <= 1'b0;
                roll_store_reg  <= roll_res;
                pitch_store_reg <= pitch_res;
                yaw_store_reg   <= yaw_res;
                m_tvalid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg <= mode_next;
        end
        if (out_load) begin
            m_tdata_reg <= {yaw_res, pitch_res, roll_res};
            m_tuser_reg <= mode_reg;
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

    // The merge stage only runs once every lane has finished.
    a_lanes_idle_in_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FUSE1 || state_reg == ST_FUSE2 || state_reg == ST_FUSE3)
        |-> !lanes_busy)
        else $error("lane still busy during merge");

    // A new sample starts all lanes on the next cycle.
    a_lanes_start: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (busy_vec == 5'b11111))
        else $error("lanes did not start on accepted transaction");

    // A result never carries the unused mode code.
    a_mode_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser != tcf_pkg::MODE_NONE))
        else $error("invalid fusion mode on output");

    // Seeding is cleared by the first result loaded into the output register.
    a_seed_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> !seed_reg)
        else $error("seed flag not cleared");

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for tilt_complementary_filter_unit: drives IMU samples,
// predicts roll, pitch, yaw and fusion mode in fixed point, and compares results.
// Depends on tcf_pkg and the filter RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int STEPS      = 18;
    localparam int STALL_MAX  = 2000;
    localparam int SETTLE     = 40;

    typedef struct packed {
        logic [19:0]        elapsed;
        logic signed [15:0] az;
        logic signed [15:0] ay;
        logic signed [15:0] ax;
        logic signed [22:0] ryaw;
        logic signed [22:0] rpitch;
        logic signed [22:0] rroll;
    } sample_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] yaw;
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
    } angles_t;

    logic                      aclk;
    logic                      aresetn;
    logic [tcf_pkg::IN_W-1:0]  s_tdata;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [tcf_pkg::OUT_W-1:0] m_tdata;
    logic [1:0]                m_tuser;
    logic                      m_tvalid;
    logic                      m_tready;
    logic                      cfg_we;
    logic [2:0]                cfg_addr;
    logic [28:0]               cfg_wdata;

    tilt_complementary_filter_unit #(.CORDIC_STEPS(STEPS)) dut (.*);

    // Filter state mirrored by the predictor.
    logic [15:0] w_blend;
    logic        yaw_on;
    logic [28:0] drift_lim;
    logic [15:0] acc_lo;
    logic [15:0] acc_hi;
    logic [22:0] gyro_min;
    longint      roll_st, pitch_st, yaw_st;
    bit          seeding;

    sample_t pending_samples[$];
    angles_t expected_angles[$];
    int      fail_count;
    int      result_count;
    int      send_idle_pct;
    int      recv_stall_pct;
    int      hold_off;
    int      quiet_cycles;
    bit      accepted_now;

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_div(longint p, longint d);
        if (p >= 0) return (p + d / 2) / d;
        return -((-p + d / 2) / d);
    endfunction

    function automatic longint clamp_angle(longint v);
        if (v > 2000000000) return 2000000000;
        if (v < -2000000000) return -2000000000;
        return v;
    endfunction

    function automatic longint labs(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Vectoring CORDIC giving atan2(y, x) in microdegrees.
    function automatic longint vector_angle(longint y, longint x);
        longint z, nx, ny;
        z = 0;
        if (x == 0 && y == 0) return 0;
        x = x * 65536;
        y = y * 65536;
        if (x < 0) begin
            z = (y >= 0) ? 180000000 : -180000000;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (y >= 0) begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
                z += tcf_pkg::ATAN_TAB[i];
            end else begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
                z -= tcf_pkg::ATAN_TAB[i];
            end
            x = nx;
            y = ny;
        end
        return z;
    endfunction

    function automatic longint fuse_tilt(ref longint st, input longint acc, longint rate,
                                         longint dt, logic [1:0] mode);
        longint g, r, w;
        w = w_blend;
        g = seeding ? acc : st + round_div(rate * dt, 1000);
        if (labs(g - acc) > longint'(drift_lim)) g = acc;
        if (mode == tcf_pkg::MODE_BLEND) r = round_div((65536 - w) * g + w * acc, 65536);
        else if (mode == tcf_pkg::MODE_GYRO) r = g;
        else r = acc;
        r = clamp_angle(r);
        st = r;
        return r;
    endfunction

    function automatic angles_t predict_angles(sample_t s);
        angles_t a;
        longint acc_r, acc_p, asum, gsum, dt;
        logic [1:0] mode;
        dt = s.elapsed;
        acc_r = vector_angle(s.az, s.ay) - 90000000;
        acc_p = vector_angle(s.az, s.ax) - 90000000;
        asum = labs(s.ax) + labs(s.ay) + labs(s.az);
        gsum = labs(s.rroll) + labs(s.rpitch) + labs(s.ryaw);
        if (asum > acc_lo && asum < acc_hi && gsum > gyro_min) mode = tcf_pkg::MODE_BLEND;
        else if (gsum > gyro_min) mode = tcf_pkg::MODE_GYRO;
        else mode = tcf_pkg::MODE_ACCEL;
        a.roll  = 32'(fuse_tilt(roll_st, acc_r, s.rroll, dt, mode));
        a.pitch = 32'(fuse_tilt(pitch_st, acc_p, s.rpitch, dt, mode));
        if (yaw_on && !seeding) yaw_st = clamp_angle(yaw_st + round_div(s.ryaw * dt, 1000));
        else yaw_st = 0;
        a.yaw = 32'(yaw_st);
        a.mode = mode;
        seeding = 0;
        return a;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 result_count, what, got, want);
        fail_count++;
    endtask

    // Input acceptance: each sample is predicted at the edge that takes it.
    always @(posedge aclk) begin
        accepted_now = aresetn && s_tvalid && s_tready;
        if (accepted_now) begin
            expected_angles.push_back(predict_angles(pending_samples.pop_front()));
        end
    end

    // Driver: presents queued samples and holds one until it is taken.
    always @(negedge aclk) begin
        if (pending_samples.size() > 0 && ($urandom_range(99) >= send_idle_pct ||
                                           (s_tvalid && !accepted_now))) begin
            s_tvalid <= 1'b1;
            s_tdata  <= tcf_pkg::IN_W'(pending_samples[0]);
        end else begin
            s_tvalid <= 1'b0;
        end
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: checks each result transaction against the oldest prediction.
    always @(posedge aclk) begin
        angles_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata};
            result_count++;
            if (expected_angles.size() == 0) begin
                report_mismatch("unexpected result", got.roll, 0);
            end else begin
                want = expected_angles.pop_front();
                if (got.roll !== want.roll) report_mismatch("roll", got.roll, want.roll);
                if (got.pitch !== want.pitch) report_mismatch("pitch", got.pitch, want.pitch);
                if (got.yaw !== want.yaw) report_mismatch("yaw", got.yaw, want.yaw);
                if (got.mode !== want.mode) report_mismatch("mode", got.mode, want.mode);
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > 20000) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [28:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            tcf_pkg::REG_BLEND_WEIGHT: w_blend   = val[15:0];
            tcf_pkg::REG_YAW_ENABLE:   yaw_on    = val[0];
            tcf_pkg::REG_DRIFT_LIMIT:  drift_lim = val;
            tcf_pkg::REG_ACCEL_LOW:    acc_lo    = val[15:0];
            tcf_pkg::REG_ACCEL_HIGH:   acc_hi    = val[15:0];
            tcf_pkg::REG_GYRO_MIN:     gyro_min  = val[22:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_samples.size() > 0 || expected_angles.size() > 0 || s_tvalid)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic sample_t rand_sample(bit calm);
        sample_t s;
        int rmax, amax;
        logic [159:0] raw;
        rmax = calm ? 3000 : 2100000;
        amax = calm ? 1500 : 17000;
        s.rroll   = 23'($urandom_range(2 * rmax) - rmax);
        s.rpitch  = 23'($urandom_range(2 * rmax) - rmax);
        s.ryaw    = 23'($urandom_range(2 * rmax) - rmax);
        s.ax      = 16'($urandom_range(2 * amax) - amax);
        s.ay      = 16'($urandom_range(2 * amax) - amax);
        s.az      = 16'($urandom_range(2 * amax) - amax);
        s.elapsed = calm ? 20'($urandom_range(2000, 8000)) : 20'($urandom_range(1000000));
        if ($urandom_range(19) == 0) begin
            raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
            s = raw[$bits(sample_t)-1:0];
        end
        return s;
    endfunction

    task automatic run_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++) pending_samples.push_back(rand_sample($urandom_range(3) != 0));
        wait_drained();
    endtask

    initial begin
        sample_t s;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        fail_count = 0;
        result_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        accepted_now = 1'b0;
        w_blend = 16'd3277;
        yaw_on = 1'b0;
        drift_lim = 29'd5000000;
        acc_lo = 16'd100;
        acc_hi = 16'd3000;
        gyro_min = 23'd300;
        roll_st = 0;
        pitch_st = 0;
        yaw_st = 0;
        seeding = 1;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: seeding, zero vector, negative x on both signs of y, extremes.
        s = '0; s.az = 1000; s.ay = -200; s.ax = 300; pending_samples.push_back(s);
        s = '0; pending_samples.push_back(s);
        s = '0; s.az = 0; s.ay = -1000; s.ax = 500; s.rroll = 500; pending_samples.push_back(s);
        s = '0; s.az = -1; s.ay = -5; s.ax = -7; s.rroll = 400; pending_samples.push_back(s);
        s = '0; s.az = 17000; s.ay = -17000; s.ax = -17000; s.rroll = 2100000;
        s.rpitch = -2100000; s.ryaw = 2100000; s.elapsed = 1000000; pending_samples.push_back(s);
        s = '1; pending_samples.push_back(s);
        s = '0; s.rroll = 23'h400000; s.ax = 16'h8000; s.ay = 16'h7fff;
        s.az = 16'h8000; s.elapsed = 20'hfffff; pending_samples.push_back(s);
        wait_drained();
        write_reg(tcf_pkg::REG_YAW_ENABLE, 29'd1);
        write_reg(tcf_pkg::REG_DRIFT_LIMIT, 29'h1fffffff);
        for (int i = 0; i < 8; i++) begin
            s = '0; s.ryaw = (i % 2) ? -23'sd2100000 : 23'sd2100000; s.rroll = 600;
            s.az = 900; s.ay = 100; s.ax = -100; s.elapsed = 1000000;
            pending_samples.push_back(s);
        end
        wait_drained();

        // Random phases with various settings and idling mixes.
        run_phase(350, 0, 0);
        write_reg(tcf_pkg::REG_BLEND_WEIGHT, 29'd0);
        write_reg(tcf_pkg::REG_GYRO_MIN, 29'h7fffff);
        run_phase(200, 75, 0);
        write_reg(tcf_pkg::REG_BLEND_WEIGHT, 29'd65535);
        write_reg(tcf_pkg::REG_GYRO_MIN, 29'd0);
        write_reg(tcf_pkg::REG_ACCEL_LOW, 29'd0);
        write_reg(tcf_pkg::REG_ACCEL_HIGH, 29'd65535);
        write_reg(tcf_pkg::REG_DRIFT_LIMIT, 29'd0);
        run_phase(300, 0, 75);
        write_reg(tcf_pkg::REG_BLEND_WEIGHT, 29'd40000);
        write_reg(tcf_pkg::REG_DRIFT_LIMIT, 29'd360000000);
        write_reg(tcf_pkg::REG_ACCEL_LOW, 29'd65535);
        write_reg(tcf_pkg::REG_ACCEL_HIGH, 29'd0);
        write_reg(tcf_pkg::REG_GYRO_MIN, 29'd2000);
        run_phase(300, 14, 14);

        // Long receiver hold-off while samples keep coming.
        write_reg(tcf_pkg::REG_BLEND_WEIGHT, 29'd3277);
        write_reg(tcf_pkg::REG_ACCEL_LOW, 29'd100);
        write_reg(tcf_pkg::REG_ACCEL_HIGH, 29'd3000);
        write_reg(tcf_pkg::REG_DRIFT_LIMIT, 29'd5000000);
        write_reg(tcf_pkg::REG_GYRO_MIN, 29'd300);
        @(negedge aclk);
        hold_off = STALL_MAX;
        run_phase(200, 0, 0);
        write_reg(tcf_pkg::REG_YAW_ENABLE, 29'd0);
        write_reg(3'd7, 29'd12345);
        run_phase(560, 0, 0);

        $display("covered %0d results over seeding, all fusion modes, register extremes",
                 result_count);
        $display("and idle, stall and long hold-off phases");
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
